>>> design/fr_pkg.sv
`timescale 1ns / 1ps

package fr_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } fr_state_t;

    // handshake between the sequencer and one of its arithmetic units
    typedef struct packed {
        logic start;
    } fr_unit_ctrl_t;

    typedef struct packed {
        logic done;
    } fr_unit_stat_t;

endpackage

>>> design/fr_gcd.sv
`timescale 1ns / 1ps

module fr_gcd
    import fr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fr_unit_ctrl_t        ctrl,
    input  logic [WIDTH-1:0]     a_in,
    input  logic [WIDTH-1:0]     b_in,
    output fr_unit_stat_t        stat,
    output logic [WIDTH-1:0]     gcd
);

    logic             busy_reg, busy_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             finish;

    // binary GCD, one shift or one subtract per cycle; the common power of
    // two is put back one left shift a cycle once both operands agree
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        finish = 1'b0;
        priority if (a_reg == b_reg)
        begin
            if (k_reg == '0)
            begin
                finish = 1'b1;
            end
            else
            begin
                a_next = {a_reg[WIDTH-2:0], 1'b0};
                b_next = {b_reg[WIDTH-2:0], 1'b0};
                k_next = k_reg - 1'b1;
            end
        end
        else if (!a_reg[0] && !b_reg[0])
        begin
            a_next = {1'b0, a_reg[WIDTH-1:1]};
            b_next = {1'b0, b_reg[WIDTH-1:1]};
            k_next = k_reg + 1'b1;
        end
        else if (!a_reg[0])
        begin
            a_next = {1'b0, a_reg[WIDTH-1:1]};
        end
        else if (!b_reg[0])
        begin
            b_next = {1'b0, b_reg[WIDTH-1:1]};
        end
        else if (a_reg > b_reg)
        begin
            a_next = (a_reg - b_reg) >> 1;
        end
        else
        begin
            b_next = (b_reg - a_reg) >> 1;
        end

        if (ctrl.start)
        begin
            a_next = a_in;
            b_next = b_in;
            k_next = '0;
        end
        busy_next = ctrl.start || (busy_reg && !finish);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign stat.done = busy_reg && finish;
    assign gcd       = a_reg;

endmodule

>>> design/fr_div.sv
`timescale 1ns / 1ps

module fr_div
    import fr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fr_unit_ctrl_t        ctrl,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output fr_unit_stat_t        stat,
    output logic [WIDTH-1:0]     quotient
);

    logic             busy_reg, busy_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;
    logic             last;

    // restoring division: one quotient bit per cycle, MSB first
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[WIDTH-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = !diff[WIDTH];
        last     = (cnt_reg == '0);
        rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], ge};
        dsr_next = dsr_reg;
        cnt_next = cnt_reg - 1'b1;
        if (ctrl.start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(WIDTH - 1);
        end
        busy_next = ctrl.start || (busy_reg && !last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done = busy_reg && last;
    assign quotient  = {quo_reg[WIDTH-2:0], ge};

endmodule

>>> design/fraction_reducer.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------------
// in      | in_valid / in_ready  | numerator, denominator
// out     | out_valid / out_ready| reduced_numerator, reduced_denominator, is_whole,
//         |                      | bad_operand
//
// One beat at a time: binary GCD (one shift or subtract a cycle), then two
// serial divisions by the GCD and a load of the output register; a zero
// operand skips the GCD and the divisions and goes straight to the load.
// in_ready is high only while the sequencer is idle. The output register
// holds a result under stall while the next beat is already being worked;
// a finished result waits until that register is free. Reset clears control.

module fraction_reducer
    import fr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] numerator,
    input  logic [WIDTH-1:0] denominator,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] reduced_numerator,
    output logic [WIDTH-1:0] reduced_denominator,
    output logic             is_whole,
    output logic             bad_operand
);

    fr_state_t        state_reg, state_next;
    logic [WIDTH-1:0] num_reg, den_reg, gcd_reg, rn_reg;
    logic             bad_reg;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_rn_reg, out_rd_reg;
    logic             out_whole_reg, out_bad_reg;

    fr_unit_ctrl_t    gcd_ctrl, div_ctrl;
    fr_unit_stat_t    gcd_stat, div_stat;
    logic [WIDTH-1:0] gcd_val, quotient;
    logic [WIDTH-1:0] div_dividend, div_divisor;
    logic             accept, zero_in, load;

    fr_gcd u_gcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (gcd_ctrl),
        .a_in  (numerator),
        .b_in  (denominator),
        .stat  (gcd_stat),
        .gcd   (gcd_val)
    );

    fr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign zero_in  = (numerator == '0) || (denominator == '0);

    always_comb
    begin
        state_next     = state_reg;
        gcd_ctrl.start = 1'b0;
        div_ctrl.start = 1'b0;
        div_dividend   = num_reg;
        div_divisor    = gcd_val;
        load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    gcd_ctrl.start = !zero_in;
                    state_next     = zero_in ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_stat.done)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                // second division reuses the divider with the held GCD
                div_dividend = den_reg;
                div_divisor  = gcd_reg;
                if (div_stat.done)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                div_dividend = den_reg;
                div_divisor  = gcd_reg;
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg <= numerator;
            den_reg <= zero_in ? '0 : denominator;
            bad_reg <= zero_in;
            rn_reg  <= '0;
            gcd_reg <= '0;
        end
        if (state_reg == ST_GCD && gcd_stat.done)
        begin
            gcd_reg <= gcd_val;
        end
        if (state_reg == ST_DIVN && div_stat.done)
        begin
            rn_reg <= quotient;
        end
        if (state_reg == ST_DIVD && div_stat.done)
        begin
            den_reg <= quotient;
        end
        if (load)
        begin
            out_rn_reg    <= rn_reg;
            out_rd_reg    <= den_reg;
            out_whole_reg <= !bad_reg && (den_reg == WIDTH'(1));
            out_bad_reg   <= bad_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign reduced_numerator   = out_rn_reg;
    assign reduced_denominator = out_rd_reg;
    assign is_whole            = out_whole_reg;
    assign bad_operand         = out_bad_reg;

endmodule

>>> design/fr_checker.sv
`timescale 1ns / 1ps

module fr_checker
    import fr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] reduced_numerator,
    input logic [WIDTH-1:0] reduced_denominator,
    input logic             is_whole,
    input logic             bad_operand
);

    // drop in_ready for the beat that was just taken
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a beat is in flight");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(reduced_numerator) && $stable(reduced_denominator)
            && $stable(is_whole) && $stable(bad_operand))
        else $error("result beat changed under stall");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_operand |-> reduced_numerator == '0
            && reduced_denominator == '0 && !is_whole)
        else $error("bad operand result not zero");

    a_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_operand |-> is_whole == (reduced_denominator == WIDTH'(1)))
        else $error("is_whole disagrees with reduced denominator");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_operand |-> reduced_numerator != '0
            && reduced_denominator != '0)
        else $error("valid reduction gave a zero term");

endmodule

bind fraction_reducer fr_checker u_fr_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fr_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 400;

    typedef logic [WIDTH-1:0] word_t;

    typedef struct packed {
        word_t num;
        word_t den;
    } fraction_t;

    typedef struct packed {
        word_t rnum;
        word_t rden;
        logic  whole;
        logic  bad;
    } reduced_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    word_t numerator = '0;
    word_t denominator = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t reduced_numerator;
    word_t reduced_denominator;
    logic  is_whole;
    logic  bad_operand;

    fraction_t pending_fractions[$];
    reduced_t  expected_reductions[$];
    fraction_t next_beat;
    reduced_t  got;
    reduced_t  want;
    int        beats_in = 0;
    int        mismatches = 0;
    int        stall_cycles = 0;
    int        send_idle_pct;
    int        recv_stall_pct;

    fraction_reducer DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .numerator           (numerator),
        .denominator         (denominator),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator),
        .is_whole            (is_whole),
        .bad_operand         (bad_operand)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic reduced_t reduce_fraction(word_t n, word_t d);
        word_t    a;
        word_t    b;
        word_t    r;
        reduced_t res;
        res = '0;
        if (n == '0 || d == '0)
        begin
            res.bad = 1'b1;
            return res;
        end
        a = n;
        b = d;
        while (b != '0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        res.rnum  = n / a;
        res.rden  = d / a;
        res.whole = (res.rden == word_t'(1));
        return res;
    endfunction

    function automatic word_t rand_word();
        return word_t'({$urandom(), $urandom()});
    endfunction

    function automatic fraction_t next_fraction();
        fraction_t f;
        int        pick;
        int        bits;
        word_t     g;
        pick = $urandom_range(99, 0);
        bits = $urandom_range(WIDTH - 1, 1);
        if (pick < 30)
        begin
            // common factor of random size times two random cofactors
            g = rand_word() >> (WIDTH - bits);
            if (g == '0)
                g = word_t'(1);
            f.num = g * (rand_word() >> bits);
            f.den = g * (rand_word() >> bits);
        end
        else if (pick < 45)
        begin
            // whole number: numerator a multiple of the denominator
            f.den = rand_word() >> (WIDTH - bits);
            f.num = f.den * (rand_word() >> bits);
        end
        else if (pick < 60)
        begin
            f.num = rand_word() << $urandom_range(WIDTH - 1, 0);
            f.den = rand_word() << $urandom_range(WIDTH - 1, 0);
        end
        else if (pick < 70)
        begin
            f.num = word_t'($urandom_range(64, 1));
            f.den = word_t'($urandom_range(64, 1));
        end
        else if (pick < 93)
        begin
            f.num = rand_word();
            f.den = rand_word();
        end
        else
        begin
            f.num = ($urandom_range(2, 0) == 0) ? '0 : rand_word();
            f.den = (f.num != '0 && $urandom_range(1, 0) == 0) ? '0 :
                    (($urandom_range(1, 0) == 0) ? '0 : rand_word());
        end
        return f;
    endfunction

    task automatic check_field(string field, word_t expected, word_t actual);
        if (expected !== actual)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, expected, actual);
        end
    endtask

    // cycle through idling phases every 40 beats
    always_comb
    begin
        case ((beats_in / 40) % 5)
            1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
            3:       begin send_idle_pct = 23; recv_stall_pct = 23; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            numerator   <= '0;
            denominator <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_reductions.push_back(reduce_fraction(numerator, denominator));
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_fractions.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_beat = pending_fractions.pop_front();
                    numerator   <= next_beat.num;
                    denominator <= next_beat.den;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                got = {reduced_numerator, reduced_denominator, is_whole, bad_operand};
                if (expected_reductions.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat: expected none, actual %0h/%0h whole=%0b bad=%0b",
                             $time, got.rnum, got.rden, got.whole, got.bad);
                end
                else
                begin
                    want = expected_reductions.pop_front();
                    check_field("reduced_numerator", want.rnum, got.rnum);
                    check_field("reduced_denominator", want.rden, got.rden);
                    check_field("is_whole", word_t'(want.whole), word_t'(got.whole));
                    check_field("bad_operand", word_t'(want.bad), word_t'(got.bad));
                end
            end
        end
    end

    // watchdog: count cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        pending_fractions.push_back('{word_t'(1), word_t'(1)});
        pending_fractions.push_back('{'0, '0});
        pending_fractions.push_back('{'0, word_t'(5)});
        pending_fractions.push_back('{word_t'(7), '0});
        pending_fractions.push_back('{'1, '0});
        pending_fractions.push_back('{'0, '1});
        pending_fractions.push_back('{'1, '1});
        pending_fractions.push_back('{'1, word_t'(1)});
        pending_fractions.push_back('{word_t'(1), '1});
        pending_fractions.push_back('{'1, '1 - word_t'(1)});
        pending_fractions.push_back('{'1, word_t'(3)});
        pending_fractions.push_back('{word_t'(1) << (WIDTH - 1), word_t'(1) << (WIDTH - 2)});
        pending_fractions.push_back('{word_t'(1) << (WIDTH - 1), word_t'(1) << (WIDTH - 1)});
        pending_fractions.push_back('{word_t'(1), word_t'(1) << (WIDTH - 1)});
        pending_fractions.push_back('{word_t'(1) << (WIDTH - 1), word_t'(1)});
        pending_fractions.push_back('{word_t'(12), word_t'(18)});
        pending_fractions.push_back('{word_t'(6), word_t'(3)});
        pending_fractions.push_back('{word_t'(3), word_t'(6)});
        pending_fractions.push_back('{'1 - word_t'(1), word_t'(2)});
        pending_fractions.push_back('{word_t'(17), word_t'(13)});
        pending_fractions.push_back('{word_t'(1000000007), word_t'(998244353)});
        repeat (RANDOM_ITEMS)
            pending_fractions.push_back(next_fraction());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_fractions.size() == 0 && !in_valid && expected_reductions.size() == 0)
               && stall_cycles < STALL_LIMIT)
            @(negedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (mismatches == 0 && expected_reductions.size() == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> fraction_reducer.f
design/fr_pkg.sv
design/fr_gcd.sv
design/fr_div.sv
design/fraction_reducer.sv
design/fr_checker.sv
bench/testbench.sv
